/* rtl/sexpr_char_lexer_macros.svh */
// Assertion macros shared by the lexer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SEXPR_CHAR_LEXER_MACROS_SVH
`define SEXPR_CHAR_LEXER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SCLX_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked on the same edge.
`define SCLX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked at the next edge.
`define SCLX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sclx_pkg.sv */
// Package for the S-expression character lexer: field widths, token and error codes,
// character constants, the result record and the character classification functions.
// No dependencies.
package sclx_pkg;

	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 3;
	localparam int BR_W    = 3;
	localparam int INT_W   = 64;
	localparam int ERR_W   = 2;
	localparam int DIGIT_W = 4;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_BRACKET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INT     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STR     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

	// Bracket codes.
	localparam logic [BR_W-1:0] BR_LPAREN = 3'd0;
	localparam logic [BR_W-1:0] BR_RPAREN = 3'd1;
	localparam logic [BR_W-1:0] BR_LSQ    = 3'd2;
	localparam logic [BR_W-1:0] BR_RSQ    = 3'd3;
	localparam logic [BR_W-1:0] BR_LCURLY = 3'd4;
	localparam logic [BR_W-1:0] BR_RCURLY = 3'd5;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_DIGIT  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNCLOSED   = 2'd2;
	localparam logic [ERR_W-1:0] ERR_BACKSLASH  = 2'd3;

	// Characters the lexer reacts to.
	localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LSQ     = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RSQ     = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_LCURLY  = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RCURLY  = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [CHAR_W-1:0] CH_APOS    = 8'h27;
	localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
	localparam logic [CHAR_W-1:0] CH_7       = 8'h37;
	localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA      = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA      = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF      = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LN      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_LT      = 8'h74;
	localparam logic [CHAR_W-1:0] CH_LR      = 8'h72;
	localparam logic [CHAR_W-1:0] CH_LV      = 8'h76;
	localparam logic [CHAR_W-1:0] CH_LX      = 8'h78;
	localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'd10;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} num_base_t;

	// One result record as it leaves the block.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BR_W-1:0]   bracket;
		logic [INT_W-1:0]  int_value;
		logic [CHAR_W-1:0] text_char;
		logic              text_valid;
		logic              token_last;
		logic [ERR_W-1:0]  error_code;
		logic              run_last;
	} result_t;

	// Classification result: hit flag and a small code or value.
	typedef struct packed {
		logic              hit;
		logic [CHAR_W-1:0] val;
	} char_class_t;

	function automatic char_class_t bracket_of(input logic [CHAR_W-1:0] c);
		char_class_t r;
		r.hit = 1'b1;
		r.val = '0;
		case (c)
			CH_LPAREN: r.val = {5'd0, BR_LPAREN};
			CH_RPAREN: r.val = {5'd0, BR_RPAREN};
			CH_LSQ:    r.val = {5'd0, BR_LSQ};
			CH_RSQ:    r.val = {5'd0, BR_RSQ};
			CH_LCURLY: r.val = {5'd0, BR_LCURLY};
			CH_RCURLY: r.val = {5'd0, BR_RCURLY};
			default:   r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Digit value of c in the given base; hit is low for a non-digit.
	function automatic char_class_t digit_of(input logic [CHAR_W-1:0] c, input num_base_t b);
		char_class_t r;
		r.hit = 1'b0;
		r.val = '0;
		if (c >= CH_0 && c <= CH_9 && (b != BASE_OCT || c <= CH_7)) begin
			r.hit = 1'b1;
			r.val = c - CH_0;
		end else if (b == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
			r.hit = 1'b1;
			r.val = c - CH_LA + HEX_ALPHA_OFS;
		end else if (b == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
			r.hit = 1'b1;
			r.val = c - CH_UA + HEX_ALPHA_OFS;
		end
		return r;
	endfunction

	// Character produced by an escape; hit is low for an escape that yields nothing.
	function automatic char_class_t escape_of(input logic [CHAR_W-1:0] c);
		char_class_t r;
		r.hit = 1'b1;
		r.val = '0;
		case (c)
			CH_LN:     r.val = CH_NL;
			CH_LT:     r.val = CH_TAB;
			CH_BSLASH: r.val = CH_BSLASH;
			CH_0:      r.val = CH_NUL;
			CH_APOS:   r.val = CH_APOS;
			CH_LR:     r.val = CH_CR;
			CH_LV:     r.val = CH_VT;
			default:   r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/sexpr_char_lexer.sv */
// Character-serial S-expression lexer: input register, one-step lexer logic and a
// two-entry result buffer. Depends on sclx_pkg and sexpr_char_lexer_macros.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  input   | in_valid / in_stall    | char_in, line_end
//  output  | out_valid / out_stall  | token_kind, bracket_code, int_value, text_char,
//          |                        | text_valid, token_last, error_code, run_last
//
// Each character passes the lexer step once; a new one can enter every cycle while the buffer has room.
// An item that makes two results (a word followed by a bracket) needs two output
// transfers, so the two-entry result buffer sets the rate when the output is the limit.
// An accepted item passes the input register and then the result buffer before its first result is offered.
// Reset returns the lexer to the idle mode with an empty word and empty buffers.
// A stall on the output holds the buffer; the input stalls once the buffer lacks room.
`include "sexpr_char_lexer_macros.svh"

module sexpr_char_lexer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sclx_pkg::CHAR_W-1:0]   char_in,
	input  logic                          line_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sclx_pkg::KIND_W-1:0]   token_kind,
	output logic [sclx_pkg::BR_W-1:0]     bracket_code,
	output logic [sclx_pkg::INT_W-1:0]    int_value,
	output logic [sclx_pkg::CHAR_W-1:0]   text_char,
	output logic                          text_valid,
	output logic                          token_last,
	output logic [sclx_pkg::ERR_W-1:0]    error_code,
	output logic                          run_last
);
	import sclx_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_IDENT = 3'd1,
		M_NUM   = 3'd2,
		M_STR   = 3'd3,
		M_ESC   = 3'd4,
		M_SKIP  = 3'd5
	} lex_mode_t;

	// Input register.
	logic              item_valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              line_end_s1;

	// Lexer state.
	lex_mode_t         mode_q;
	logic [CHAR_W-1:0] held_char_q;
	logic              held_valid_q;
	logic [INT_W-1:0]  acc_q;
	num_base_t         base_q;
	logic              lead_zero_q;

	// Result buffer.
	result_t           ent_q [2];
	logic [1:0]        cnt_q;

	// Next state and results of one step.
	lex_mode_t         mode_d;
	logic [CHAR_W-1:0] held_char_d;
	logic              held_valid_d;
	logic [INT_W-1:0]  acc_d;
	num_base_t         base_d;
	logic              lead_zero_d;
	result_t           res0;
	result_t           res1;
	logic [1:0]        res_n;

	logic              pop;
	logic              advance;
	logic              load;
	logic [1:0]        room;
	logic [1:0]        kept;
	logic [1:0]        cnt_d;
	result_t           ent0_d;
	result_t           ent1_d;

	char_class_t       br;
	char_class_t       dig;
	char_class_t       esc;
	logic              is_delim;
	logic [INT_W-1:0]  acc_scaled;

	// Lexer step for the item in the input register.
	always_comb begin
		mode_d       = mode_q;
		held_char_d  = held_char_q;
		held_valid_d = held_valid_q;
		acc_d        = acc_q;
		base_d       = base_q;
		lead_zero_d  = lead_zero_q;
		res0         = '0;
		res1         = '0;
		res_n        = 2'd0;
		br           = bracket_of(char_s1);
		esc          = escape_of(char_s1);
		dig          = digit_of(char_s1, base_q);
		is_delim     = br.hit || char_s1 == CH_SPACE || char_s1 == CH_TAB ||
			char_s1 == CH_QUOTE;
		case (base_q)
			BASE_HEX: acc_scaled = {acc_q[INT_W-5:0], 4'd0};
			BASE_OCT: acc_scaled = {acc_q[INT_W-4:0], 3'd0};
			default:  acc_scaled = {acc_q[INT_W-4:0], 3'd0} + {acc_q[INT_W-2:0], 1'b0};
		endcase

		if (line_end_s1) begin
			// Line end flushes the open word or reports an open string.
			if (mode_q == M_IDENT && held_valid_q) begin
				res0.kind = KIND_IDENT;
				res0.text_char = held_char_q;
				res0.text_valid = 1'b1;
				res0.token_last = 1'b1;
				res_n = 2'd1;
			end else if (mode_q == M_NUM) begin
				res0.kind = KIND_INT;
				res0.int_value = acc_q;
				res_n = 2'd1;
			end else if (mode_q == M_STR || mode_q == M_ESC) begin
				res0.kind = KIND_ERROR;
				res0.error_code = ERR_UNCLOSED;
				res_n = 2'd1;
			end
			mode_d = M_IDLE;
			held_char_d = '0;
			held_valid_d = 1'b0;
			acc_d = '0;
			base_d = BASE_DEC;
			lead_zero_d = 1'b0;
		end else begin
			case (mode_q)
				M_SKIP: begin
				end
				M_STR: begin
					if (char_s1 == CH_QUOTE) begin
						// Closing quote; an empty string gets a marker result.
						res0.kind = KIND_STR;
						res0.text_char = held_valid_q ? held_char_q : CH_NUL;
						res0.text_valid = held_valid_q;
						res0.token_last = 1'b1;
						res_n = 2'd1;
						mode_d = M_IDLE;
						held_char_d = '0;
						held_valid_d = 1'b0;
						acc_d = '0;
						base_d = BASE_DEC;
						lead_zero_d = 1'b0;
					end else if (char_s1 == CH_BSLASH) begin
						mode_d = M_ESC;
					end else begin
						if (held_valid_q) begin
							res0.kind = KIND_STR;
							res0.text_char = held_char_q;
							res0.text_valid = 1'b1;
							res_n = 2'd1;
						end
						held_char_d = char_s1;
						held_valid_d = 1'b1;
					end
				end
				M_ESC: begin
					mode_d = M_STR;
					if (char_s1 == CH_QUOTE) begin
						// The quote still closes the string, which then ends in a backslash.
						res0.kind = KIND_ERROR;
						res0.error_code = ERR_BACKSLASH;
						res_n = 2'd1;
						mode_d = M_SKIP;
						held_char_d = '0;
						held_valid_d = 1'b0;
						acc_d = '0;
						base_d = BASE_DEC;
						lead_zero_d = 1'b0;
					end else if (esc.hit) begin
						if (held_valid_q) begin
							res0.kind = KIND_STR;
							res0.text_char = held_char_q;
							res0.text_valid = 1'b1;
							res_n = 2'd1;
						end
						held_char_d = esc.val;
						held_valid_d = 1'b1;
					end
				end
				M_IDLE, M_IDENT, M_NUM: begin
					if (is_delim) begin
						// A delimiter flushes the word, then a bracket follows it.
						if (mode_q == M_IDENT && held_valid_q) begin
							res0.kind = KIND_IDENT;
							res0.text_char = held_char_q;
							res0.text_valid = 1'b1;
							res0.token_last = 1'b1;
							res_n = 2'd1;
						end else if (mode_q == M_NUM) begin
							res0.kind = KIND_INT;
							res0.int_value = acc_q;
							res_n = 2'd1;
						end
						if (br.hit) begin
							if (res_n == 2'd0) begin
								res0.kind = KIND_BRACKET;
								res0.bracket = br.val[BR_W-1:0];
							end else begin
								res1.kind = KIND_BRACKET;
								res1.bracket = br.val[BR_W-1:0];
							end
							res_n = res_n + 2'd1;
						end
						mode_d = (char_s1 == CH_QUOTE) ? M_STR : M_IDLE;
						held_char_d = '0;
						held_valid_d = 1'b0;
						acc_d = '0;
						base_d = BASE_DEC;
						lead_zero_d = 1'b0;
					end else if (mode_q == M_IDLE) begin
						// First character of a word picks integer or identifier.
						held_char_d = '0;
						held_valid_d = 1'b0;
						acc_d = '0;
						base_d = BASE_DEC;
						lead_zero_d = 1'b0;
						if (char_s1 >= CH_0 && char_s1 <= CH_9) begin
							mode_d = M_NUM;
							if (char_s1 == CH_0) begin
								base_d = BASE_OCT;
								lead_zero_d = 1'b1;
							end else begin
								acc_d = {{(INT_W-CHAR_W){1'b0}}, char_s1 - CH_0};
							end
						end else begin
							mode_d = M_IDENT;
							held_char_d = char_s1;
							held_valid_d = 1'b1;
						end
					end else if (mode_q == M_IDENT) begin
						if (held_valid_q) begin
							res0.kind = KIND_IDENT;
							res0.text_char = held_char_q;
							res0.text_valid = 1'b1;
							res_n = 2'd1;
						end
						held_char_d = char_s1;
						held_valid_d = 1'b1;
					end else begin
						// Number digit; an x right after the leading zero selects hex.
						lead_zero_d = 1'b0;
						if (lead_zero_q && char_s1 == CH_LX) begin
							base_d = BASE_HEX;
						end else if (!dig.hit) begin
							res0.kind = KIND_ERROR;
							res0.error_code = ERR_BAD_DIGIT;
							res_n = 2'd1;
							mode_d = M_SKIP;
							held_char_d = '0;
							held_valid_d = 1'b0;
							acc_d = '0;
							base_d = BASE_DEC;
						end else begin
							acc_d = acc_scaled + {{(INT_W-DIGIT_W){1'b0}}, dig.val[DIGIT_W-1:0]};
						end
					end
				end
				default: begin
					mode_d = M_IDLE;
					held_char_d = '0;
					held_valid_d = 1'b0;
					acc_d = '0;
					base_d = BASE_DEC;
					lead_zero_d = 1'b0;
				end
			endcase
		end

		// The last result of the step carries run_last.
		if (res_n == 2'd2) begin
			res1.run_last = 1'b1;
		end else begin
			res0.run_last = 1'b1;
		end
	end

	// Handshake: the step runs only when its results fit in the buffer.
	assign pop      = out_valid && !out_stall;
	assign kept     = cnt_q - {1'b0, pop};
	assign room     = 2'd2 - kept;
	assign advance  = item_valid_s1 && (res_n <= room);
	assign in_stall = item_valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	// Buffer update: shift out the transfer, then append the new results.
	always_comb begin
		ent0_d = pop ? ent_q[1] : ent_q[0];
		ent1_d = ent_q[1];
		cnt_d  = kept;
		if (advance) begin
			cnt_d = kept + res_n;
			if (kept == 2'd0) begin
				ent0_d = res0;
				ent1_d = res1;
			end else if (kept == 2'd1) begin
				ent1_d = res0;
			end
		end
	end

	// Control and lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			cnt_q         <= 2'd0;
			mode_q        <= M_IDLE;
			held_char_q   <= '0;
			held_valid_q  <= 1'b0;
			acc_q         <= '0;
			base_q        <= BASE_DEC;
			lead_zero_q   <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (load) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q       <= mode_d;
				held_char_q  <= held_char_d;
				held_valid_q <= held_valid_d;
				acc_q        <= acc_d;
				base_q       <= base_d;
				lead_zero_q  <= lead_zero_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load) begin
			char_s1     <= char_in;
			line_end_s1 <= line_end;
		end
		ent_q[0] <= ent0_d;
		ent_q[1] <= ent1_d;
	end

	assign out_valid    = cnt_q != 2'd0;
	assign token_kind   = ent_q[0].kind;
	assign bracket_code = ent_q[0].bracket;
	assign int_value    = ent_q[0].int_value;
	assign text_char    = ent_q[0].text_char;
	assign text_valid   = ent_q[0].text_valid;
	assign token_last   = ent_q[0].token_last;
	assign error_code   = ent_q[0].error_code;
	assign run_last     = ent_q[0].run_last;

	`SCLX_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2, "result buffer count out of range")
	`SCLX_ASSERT_NEXT(a_s1_held, item_valid_s1 && !advance,
		item_valid_s1 && $stable(char_s1) && $stable(line_end_s1),
		"waiting input item was lost or changed")
	`SCLX_ASSERT_SAME(a_err_kind, out_valid,
		(token_kind == KIND_ERROR) == (error_code != ERR_NONE),
		"error code does not match token kind")
	`SCLX_ASSERT_SAME(a_last_text, out_valid && token_last,
		token_kind == KIND_IDENT || token_kind == KIND_STR,
		"token_last on a non-text result")
	`SCLX_ASSERT_SAME(a_empty_str, out_valid && token_kind == KIND_STR && !text_valid,
		token_last, "empty string marker without token_last")

endmodule

/* tb/sexpr_char_lexer_tb.sv */
// Testbench for the S-expression character lexer: directed and random character streams,
// with a built-in token predictor and an in-order result checker.
// Depends on sclx_pkg and the sexpr_char_lexer RTL.
`timescale 1ns / 1ps

module sexpr_char_lexer_tb;
	import sclx_pkg::*;

	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int BURST_ITEMS   = 200;
	localparam int DRAIN_CYCLES  = 10;

	// Lexer modes of the predictor.
	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_IDENT,
		LEX_NUM,
		LEX_STR,
		LEX_ESC,
		LEX_SKIP
	} lex_mode_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CHAR_W-1:0]   char_in;
	logic                line_end;
	logic                out_valid;
	logic                out_stall;
	logic [KIND_W-1:0]   token_kind;
	logic [BR_W-1:0]     bracket_code;
	logic [INT_W-1:0]    int_value;
	logic [CHAR_W-1:0]   text_char;
	logic                text_valid;
	logic                token_last;
	logic [ERR_W-1:0]    error_code;
	logic                run_last;

	// Predictor state.
	lex_mode_t           lex_state;
	logic [CHAR_W-1:0]   pend_char;
	logic                pend_valid;
	logic [INT_W-1:0]    num_acc;
	num_base_t           num_base;
	logic                lead_zero;

	result_t             step_tokens[$];
	result_t             expected_tokens[$];

	int                  idle_pct;
	int                  stall_left;
	int                  idle_cycles;
	int                  mismatches;
	int                  items_sent;
	int                  tokens_checked;
	int                  lexer_errors;

	sexpr_char_lexer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_in      (char_in),
		.line_end     (line_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.bracket_code (bracket_code),
		.int_value    (int_value),
		.text_char    (text_char),
		.text_valid   (text_valid),
		.token_last   (token_last),
		.error_code   (error_code),
		.run_last     (run_last)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Token predictor
	// ------------------------------------------------------------------

	function automatic logic is_delim(input logic [CHAR_W-1:0] c);
		return c == CH_LPAREN || c == CH_RPAREN || c == CH_LSQ || c == CH_RSQ ||
			c == CH_LCURLY || c == CH_RCURLY || c == CH_SPACE || c == CH_TAB ||
			c == CH_QUOTE;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind,
			input logic [BR_W-1:0] br, input logic [INT_W-1:0] iv,
			input logic [CHAR_W-1:0] ch, input logic tv, input logic last,
			input logic [ERR_W-1:0] err);
		result_t t;
		t.kind       = kind;
		t.bracket    = br;
		t.int_value  = iv;
		t.text_char  = ch;
		t.text_valid = tv;
		t.token_last = last;
		t.error_code = err;
		t.run_last   = 1'b0;
		if (step_tokens.size() < 2)
			step_tokens = {step_tokens, t};
	endfunction

	function automatic void clear_word();
		pend_char  = '0;
		pend_valid = 1'b0;
		num_acc    = '0;
		num_base   = BASE_DEC;
		lead_zero  = 1'b0;
	endfunction

	// A string character is held back one step so the final one can be marked.
	function automatic void hold_string_char(input logic [CHAR_W-1:0] ch);
		if (pend_valid)
			add_token(KIND_STR, '0, '0, pend_char, 1'b1, 1'b0, ERR_NONE);
		pend_char  = ch;
		pend_valid = 1'b1;
	endfunction

	// Flushes an open identifier or integer when a word ends.
	function automatic void close_word();
		if (lex_state == LEX_IDENT && pend_valid)
			add_token(KIND_IDENT, '0, '0, pend_char, 1'b1, 1'b1, ERR_NONE);
		else if (lex_state == LEX_NUM)
			add_token(KIND_INT, '0, num_acc, '0, 1'b0, 1'b0, ERR_NONE);
	endfunction

	// Feeds one character into the current integer literal.
	function automatic void number_step(input logic [CHAR_W-1:0] c);
		logic [INT_W-1:0] digit;
		logic             ok;
		logic [INT_W-1:0] radix;
		if (lead_zero) begin
			lead_zero = 1'b0;
			if (c == CH_LX) begin
				num_base = BASE_HEX;
				return;
			end
		end
		ok    = 1'b0;
		digit = '0;
		if (c >= CH_0 && c <= CH_9 && (num_base != BASE_OCT || c <= CH_7)) begin
			ok    = 1'b1;
			digit = INT_W'(c - CH_0);
		end else if (num_base == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
			ok    = 1'b1;
			digit = INT_W'(c - CH_LA) + 10;
		end else if (num_base == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
			ok    = 1'b1;
			digit = INT_W'(c - CH_UA) + 10;
		end
		if (!ok) begin
			add_token(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, ERR_BAD_DIGIT);
			clear_word();
			lex_state = LEX_SKIP;
			return;
		end
		case (num_base)
			BASE_HEX: radix = 16;
			BASE_OCT: radix = 8;
			default:  radix = 10;
		endcase
		num_acc = num_acc * radix + digit;
	endfunction

	// Works out the results of one accepted item and queues them.
	function automatic void lex_predict(input logic [CHAR_W-1:0] c, input logic le);
		logic             is_br;
		logic [BR_W-1:0]  br;
		step_tokens.delete();
		is_br = 1'b1;
		br    = BR_LPAREN;
		case (c)
			CH_LPAREN: br = BR_LPAREN;
			CH_RPAREN: br = BR_RPAREN;
			CH_LSQ:    br = BR_LSQ;
			CH_RSQ:    br = BR_RSQ;
			CH_LCURLY: br = BR_LCURLY;
			CH_RCURLY: br = BR_RCURLY;
			default:   is_br = 1'b0;
		endcase

		if (le) begin
			if (lex_state == LEX_STR || lex_state == LEX_ESC)
				add_token(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, ERR_UNCLOSED);
			else
				close_word();
			lex_state = LEX_IDLE;
			clear_word();
		end else begin
			case (lex_state)
				LEX_SKIP: begin
				end
				LEX_STR: begin
					if (c == CH_QUOTE) begin
						if (pend_valid)
							add_token(KIND_STR, '0, '0, pend_char, 1'b1, 1'b1, ERR_NONE);
						else
							add_token(KIND_STR, '0, '0, '0, 1'b0, 1'b1, ERR_NONE);
						clear_word();
						lex_state = LEX_IDLE;
					end else if (c == CH_BSLASH) begin
						lex_state = LEX_ESC;
					end else begin
						hold_string_char(c);
					end
				end
				LEX_ESC: begin
					lex_state = LEX_STR;
					case (c)
						CH_QUOTE: begin
							add_token(KIND_ERROR, '0, '0, '0, 1'b0, 1'b0, ERR_BACKSLASH);
							clear_word();
							lex_state = LEX_SKIP;
						end
						CH_LN:     hold_string_char(CH_NL);
						CH_LT:     hold_string_char(CH_TAB);
						CH_BSLASH: hold_string_char(CH_BSLASH);
						CH_0:      hold_string_char(CH_NUL);
						CH_APOS:   hold_string_char(CH_APOS);
						CH_LR:     hold_string_char(CH_CR);
						CH_LV:     hold_string_char(CH_VT);
						default: begin
						end
					endcase
				end
				default: begin
					if (is_delim(c)) begin
						close_word();
						clear_word();
						lex_state = (c == CH_QUOTE) ? LEX_STR : LEX_IDLE;
						if (is_br)
							add_token(KIND_BRACKET, br, '0, '0, 1'b0, 1'b0, ERR_NONE);
					end else if (lex_state == LEX_IDLE) begin
						clear_word();
						if (c >= CH_0 && c <= CH_9) begin
							lex_state = LEX_NUM;
							if (c == CH_0) begin
								num_base  = BASE_OCT;
								lead_zero = 1'b1;
							end else begin
								num_acc = INT_W'(c - CH_0);
							end
						end else begin
							lex_state  = LEX_IDENT;
							pend_char  = c;
							pend_valid = 1'b1;
						end
					end else if (lex_state == LEX_IDENT) begin
						if (pend_valid)
							add_token(KIND_IDENT, '0, '0, pend_char, 1'b1, 1'b0, ERR_NONE);
						pend_char  = c;
						pend_valid = 1'b1;
					end else begin
						number_step(c);
					end
				end
			endcase
		end

		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].run_last = 1'b1;
		expected_tokens = {expected_tokens, step_tokens};
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Sends one item; called at a falling edge and returns at a falling edge.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic le);
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= c;
		line_end <= le;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		lex_predict(c, le);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic send_line_end();
		send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Any byte that continues a word; digits may be excluded for a word start.
	function automatic logic [CHAR_W-1:0] word_byte(input logic allow_digit);
		logic [CHAR_W-1:0] b;
		do begin
			if ($urandom_range(0, 2) != 0)
				b = CH_LA + CHAR_W'($urandom_range(0, 25));
			else
				b = CHAR_W'($urandom_range(0, 255));
		end while (is_delim(b) || (!allow_digit && b >= CH_0 && b <= CH_9));
		return b;
	endfunction

	// Random source lines built mostly from well-formed tokens, with some noise.
	task automatic run_random_lines(input int target, input logic with_idle);
		int                start;
		int                n_tok;
		int                pick;
		int                len;
		int                ending;
		logic [CHAR_W-1:0] ch;
		string             digits_hex;
		string             bad_digits;
		digits_hex = "0123456789abcdefABCDEF";
		bad_digits = "89gxzG";
		start = items_sent;
		while (items_sent - start < target) begin
			if (with_idle)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 35;
				endcase
			n_tok = $urandom_range(1, 6);
			repeat (n_tok) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					// Bracket.
					case ($urandom_range(0, 5))
						0: send_char(CH_LPAREN, 1'b0);
						1: send_char(CH_RPAREN, 1'b0);
						2: send_char(CH_LSQ, 1'b0);
						3: send_char(CH_RSQ, 1'b0);
						4: send_char(CH_LCURLY, 1'b0);
						default: send_char(CH_RCURLY, 1'b0);
					endcase
				end else if (pick < 40) begin
					// Integer literal in one of the three bases, sometimes at the 64-bit edge.
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 22) : $urandom_range(1, 4);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: begin
							send_char(CH_0 + CHAR_W'($urandom_range(1, 9)), 1'b0);
							repeat (len - 1)
								send_char(CH_0 + CHAR_W'($urandom_range(0, 9)), 1'b0);
						end
						4, 5: begin
							send_char(CH_0, 1'b0);
							repeat (len)
								send_char(CH_0 + CHAR_W'($urandom_range(0, 7)), 1'b0);
						end
						6, 7, 8: begin
							send_text("0x");
							repeat (len)
								send_char(digits_hex[$urandom_range(0, 21)], 1'b0);
						end
						default:
							case ($urandom_range(0, 2))
								0: send_text("18446744073709551615");
								1: send_text("0xFFFFFFFFFFFFFFFF");
								default: send_text("18446744073709551616");
							endcase
					endcase
					if ($urandom_range(0, 9) == 0)
						send_char(bad_digits[$urandom_range(0, 5)], 1'b0);
				end else if (pick < 60) begin
					// Identifier of arbitrary bytes.
					send_char(word_byte(1'b0), 1'b0);
					repeat ($urandom_range(0, 7))
						send_char(word_byte(1'b1), 1'b0);
				end else if (pick < 80) begin
					// String literal with plain bytes and escapes.
					send_char(CH_QUOTE, 1'b0);
					repeat ($urandom_range(0, 6)) begin
						if ($urandom_range(0, 9) < 7) begin
							do
								ch = CHAR_W'($urandom_range(0, 255));
							while (ch == CH_QUOTE || ch == CH_BSLASH);
							send_char(ch, 1'b0);
						end else begin
							send_char(CH_BSLASH, 1'b0);
							case ($urandom_range(0, 7))
								0: send_char(CH_LN, 1'b0);
								1: send_char(CH_LT, 1'b0);
								2: send_char(CH_BSLASH, 1'b0);
								3: send_char(CH_0, 1'b0);
								4: send_char(CH_APOS, 1'b0);
								5: send_char(CH_LR, 1'b0);
								6: send_char(CH_LV, 1'b0);
								default: begin
									do
										ch = CHAR_W'($urandom_range(0, 255));
									while (ch == CH_QUOTE);
									send_char(ch, 1'b0);
								end
							endcase
						end
					end
					ending = $urandom_range(0, 19);
					if (ending < 17) begin
						send_char(CH_QUOTE, 1'b0);
					end else if (ending < 19) begin
						send_char(CH_BSLASH, 1'b0);
						send_char(CH_QUOTE, 1'b0);
					end
				end else if (pick < 90) begin
					send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
				end else begin
					send_char(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
				end
				if ($urandom_range(0, 1) != 0)
					send_char(($urandom_range(0, 3) != 0) ? CH_SPACE : CH_TAB, 1'b0);
			end
			if ($urandom_range(0, 9) != 0)
				send_line_end();
		end
	endtask

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	task automatic test_brackets();
		send_text("()[]{}");
		send_line_end();
	endtask

	// A lone zero, a bare 0x prefix, and an octal literal hit by a bad digit.
	task automatic test_leading_zero();
		send_text("0 0x");
		send_line_end();
		send_text("07x 5");
		send_line_end();
	endtask

	// Identifier cut by a bracket, and one made of a single high byte flushed by line end.
	task automatic test_identifiers();
		send_text("ab(");
		send_char(8'hFF, 1'b0);
		send_line_end();
	endtask

	// Empty string, unclosed string and a string ending in a backslash.
	task automatic test_strings();
		send_text("\"\"");
		send_text("\"a\\q");
		send_line_end();
		send_text("\"b\\\"");
		send_line_end();
	endtask

	task automatic test_random_text();
		run_random_lines(RANDOM_ITEMS, 1'b1);
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_full_rate();
		idle_pct = 0;
		run_random_lines(BURST_ITEMS, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	// Random stall bursts on the result channel.
	always @(negedge clk) begin : drive_out_stall
		logic hold;
		if (stall_left > 0) begin
			hold = 1'b1;
			stall_left--;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			hold = 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			hold = 1'b0;
		end
		out_stall <= hold;
	end

	task automatic check_field(input string name, input logic [INT_W-1:0] want,
			input logic [INT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Each result transfer is compared with the oldest expected token.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: token_kind %0d", token_kind);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				tokens_checked++;
				if (want.kind == KIND_ERROR)
					lexer_errors++;
				check_field("token_kind", INT_W'(want.kind), INT_W'(token_kind));
				check_field("bracket_code", INT_W'(want.bracket), INT_W'(bracket_code));
				check_field("int_value", want.int_value, int_value);
				check_field("text_char", INT_W'(want.text_char), INT_W'(text_char));
				check_field("text_valid", INT_W'(want.text_valid), INT_W'(text_valid));
				check_field("token_last", INT_W'(want.token_last), INT_W'(token_last));
				check_field("error_code", INT_W'(want.error_code), INT_W'(error_code));
				check_field("run_last", INT_W'(want.run_last), INT_W'(run_last));
			end
		end
	end

	// Ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		char_in        = '0;
		line_end       = 1'b0;
		out_stall      = 1'b0;
		idle_pct       = 0;
		stall_left     = 0;
		idle_cycles    = 0;
		mismatches     = 0;
		items_sent     = 0;
		tokens_checked = 0;
		lexer_errors   = 0;
		lex_state      = LEX_IDLE;
		clear_word();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 20;
		test_brackets();
		test_leading_zero();
		test_identifiers();
		test_strings();
		test_random_text();
		test_full_rate();

		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters and line ends; checked %0d tokens, %0d of them lexer errors.",
			items_sent, tokens_checked, lexer_errors);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/sclx_pkg.sv
rtl/sexpr_char_lexer.sv
tb/sexpr_char_lexer_tb.sv
